@@ design/alr_pkg.sv @@
// Shared types and fixed output widths for the antialiased line rasterizer.
package alr_pkg;

  localparam int OUT_TW   = 48;
  localparam int PX_W     = 6;
  localparam int PX2_W    = 7;
  localparam int COV_W    = 8;
  localparam int GRAD_FR  = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ORDER,
    ST_DIV_INIT,
    ST_DIV,
    ST_GRAD,
    ST_POS,
    ST_EMIT_A,
    ST_EMIT_B,
    ST_CHECK
  } alr_state_t;

  typedef enum logic [1:0] {
    SEL_FIRST,
    SEL_MID,
    SEL_LAST
  } alr_sel_t;

  typedef struct packed {
    logic     load;
    logic     order;
    logic     div_init;
    logic     div_step;
    logic     grad;
    logic     pos;
    logic     emit_a;
    logic     write_out;
    logic     start_mid;
    logic     adv;
    alr_sel_t sel;
  } alr_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mid_avail;
    logic out_free;
  } alr_sts_t;

endpackage

@@ design/alr_ctrl.sv @@
// Controller state machine that sequences setup, division and column emission.
module alr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output alr_pkg::alr_cmd_t cmd,
  input  alr_pkg::alr_sts_t sts
);
  import alr_pkg::*;

  alr_state_t state_r, state_nxt;
  alr_sel_t   sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= SEL_FIRST;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_ORDER;
      end
      ST_ORDER:    state_nxt = ST_DIV_INIT;
      ST_DIV_INIT: state_nxt = ST_DIV;
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_GRAD;
      end
      ST_GRAD: state_nxt = ST_POS;
      ST_POS: begin
        state_nxt = ST_EMIT_A;
        sel_nxt   = SEL_FIRST;
      end
      ST_EMIT_A: state_nxt = ST_EMIT_B;
      ST_EMIT_B: begin
        if (sts.out_free) begin
          state_nxt = (sel_r == SEL_LAST) ? ST_IDLE : ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = ST_EMIT_A;
        sel_nxt   = sts.mid_avail ? SEL_MID : SEL_LAST;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.sel   = sel_r;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_ORDER:    cmd.order    = 1'b1;
      ST_DIV_INIT: cmd.div_init = 1'b1;
      ST_DIV:      cmd.div_step = !sts.div_done;
      ST_GRAD:     cmd.grad     = 1'b1;
      ST_POS:      cmd.pos      = 1'b1;
      ST_EMIT_A:   cmd.emit_a   = 1'b1;
      ST_EMIT_B: begin
        cmd.write_out = sts.out_free;
        cmd.start_mid = sts.out_free && (sel_r == SEL_FIRST);
        cmd.adv       = sts.out_free && (sel_r == SEL_MID);
      end
      ST_CHECK: ;
      default: ;
    endcase
  end

endmodule

@@ design/alr_dp.sv @@
// Datapath: endpoint ordering, gradient divider, position stepping and coverage.
module alr_dp #(
  parameter int COORD_INT_BITS  = 6,
  parameter int COORD_FRAC_BITS = 4,
  parameter int COVER_BITS      = 8,
  parameter int IN_TW           = 40
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [IN_TW-1:0]            in_tdata,
  input  alr_pkg::alr_cmd_t           cmd,
  output alr_pkg::alr_sts_t           sts,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [alr_pkg::OUT_TW-1:0]  out_tdata,
  output logic                        out_tlast
);
  import alr_pkg::*;

  localparam int I    = COORD_INT_BITS;
  localparam int F    = COORD_FRAC_BITS;
  localparam int CW   = I + F;
  localparam int ND   = CW + GRAD_FR;
  localparam int GW   = GRAD_FR + 2;
  localparam int DW   = F + 1;
  localparam int PF   = GRAD_FR + F;
  localparam int PW   = CW + GRAD_FR + 3;
  localparam int MW   = PW - PF;
  localparam int VW   = PF + 1 + DW;
  localparam int CBW  = PF + F;
  localparam int RW   = VW + COVER_BITS;
  localparam int CVW  = (COVER_BITS > COV_W) ? COVER_BITS : COV_W;
  localparam int CNTW = $clog2(ND + 1);
  localparam int TILE_MAX = (1 << I) - 1;
  localparam int CMAX     = (1 << COVER_BITS) - 1;

  // Captured raw endpoints.
  logic [CW-1:0] rsx_r, rsy_r, rex_r, rey_r;
  // Ordered, axis-swapped endpoints.
  logic [CW-1:0] ax_r, ay_r, bx_r, by_r, dx_r, mag_r;
  logic          steep_r, neg_r;
  // Divider.
  logic [CW-1:0]   rem_r;
  logic [ND-1:0]   dq_r;
  logic [CNTW-1:0] cnt_r;
  // Gradient and endpoint terms.
  logic signed [GW-1:0] g_r;
  logic signed [DW-1:0] d1_r, d2_r;
  logic [DW-1:0]        w1_r, w2_r;
  logic [I:0]           xe1_r, xe2_r;
  // Positions.
  logic signed [PW-1:0] p1_r, p2_r, step_r, t_r;
  logic [I-1:0]         col1_r, col2_r;
  logic [I:0]           x_r;
  // Emission stage.
  logic [VW-1:0] va_r, vb_r;
  logic [I-1:0]  colA_r, minA_r;
  logic          lastA_r;
  // Output register.
  logic              ov_r;
  logic [OUT_TW-1:0] od_r;
  logic              ol_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsx_r <= in_tdata[CW-1:0];
      rsy_r <= in_tdata[2*CW-1:CW];
      rex_r <= in_tdata[3*CW-1:2*CW];
      rey_r <= in_tdata[4*CW-1:3*CW];
    end
  end

  // Steep test and left-to-right ordering.
  logic [CW-1:0] adx, ady, oax, oay, obx, oby, max_c, may_c, mbx_c, mby_c;
  logic          steep_c;
  always_comb begin
    adx     = (rex_r >= rsx_r) ? rex_r - rsx_r : rsx_r - rex_r;
    ady     = (rey_r >= rsy_r) ? rey_r - rsy_r : rsy_r - rey_r;
    steep_c = ady > adx;
    max_c   = steep_c ? rsy_r : rsx_r;
    may_c   = steep_c ? rsx_r : rsy_r;
    mbx_c   = steep_c ? rey_r : rex_r;
    mby_c   = steep_c ? rex_r : rey_r;
    if (max_c > mbx_c) begin
      oax = mbx_c; oay = mby_c; obx = max_c; oby = may_c;
    end else begin
      oax = max_c; oay = may_c; obx = mbx_c; oby = mby_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.order) begin
      ax_r    <= oax;
      ay_r    <= oay;
      bx_r    <= obx;
      by_r    <= oby;
      steep_r <= steep_c;
      dx_r    <= obx - oax;
      neg_r   <= oby < oay;
      mag_r   <= (oby >= oay) ? oby - oay : oay - oby;
    end
  end

  // Restoring divider, one quotient bit per cycle; quotient shifts into dq_r.
  logic [CW:0] rem_sh;
  logic        qbit;
  assign rem_sh = {rem_r, dq_r[ND-1]};
  assign qbit   = rem_sh >= {1'b0, dx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_init) begin
      cnt_r <= CNTW'(ND);
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= '0;
      dq_r  <= {mag_r, {GRAD_FR{1'b0}}};
    end else if (cmd.div_step) begin
      rem_r <= qbit ? CW'(rem_sh - {1'b0, dx_r}) : rem_sh[CW-1:0];
      dq_r  <= {dq_r[ND-2:0], qbit};
    end
  end

  // Endpoint rounding terms.
  logic [CW:0] hs1, hs2;
  assign hs1 = {1'b0, ax_r} + (CW+1)'(1 << (F - 1));
  assign hs2 = {1'b0, bx_r} + (CW+1)'(1 << (F - 1));

  logic signed [GW-1:0] qs;
  assign qs = $signed({1'b0, dq_r[GRAD_FR:0]});

  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      if (dx_r == '0) g_r <= GW'(1 << GRAD_FR);
      else            g_r <= neg_r ? -qs : qs;
      xe1_r <= hs1[CW:F];
      xe2_r <= hs2[CW:F];
      d1_r  <= DW'($signed({1'b0, hs1[CW:F], {F{1'b0}}}) - $signed({2'b0, ax_r}));
      d2_r  <= DW'($signed({1'b0, hs2[CW:F], {F{1'b0}}}) - $signed({2'b0, bx_r}));
      w1_r  <= DW'(1 << F) - {1'b0, hs1[F-1:0]};
      w2_r  <= {1'b0, hs2[F-1:0]};
    end
  end

  logic signed [GW+DW-1:0] gd1, gd2;
  assign gd1 = g_r * d1_r;
  assign gd2 = g_r * d2_r;

  always_ff @(posedge clk) begin
    if (cmd.pos) begin
      p1_r   <= $signed({3'b000, ay_r, {GRAD_FR{1'b0}}}) + PW'(gd1);
      p2_r   <= $signed({3'b000, by_r, {GRAD_FR{1'b0}}}) + PW'(gd2);
      step_r <= PW'(g_r) <<< F;
      col1_r <= (xe1_r > (I+1)'(TILE_MAX)) ? I'(TILE_MAX) : xe1_r[I-1:0];
      col2_r <= (xe2_r > (I+1)'(TILE_MAX)) ? I'(TILE_MAX) : xe2_r[I-1:0];
    end
  end

  // Interior column stepping.
  always_ff @(posedge clk) begin
    if (cmd.start_mid) begin
      x_r <= {1'b0, col1_r} + 1'b1;
      t_r <= p1_r + step_r;
    end else if (cmd.adv) begin
      x_r <= x_r + 1'b1;
      t_r <= t_r + step_r;
    end
  end

  // First emission stage: pick the column, split the position, weight it.
  logic signed [PW-1:0] pos_c;
  logic [DW-1:0]        w_c;
  logic [I-1:0]         col_c;
  logic [PF-1:0]        f_c;
  logic signed [MW-1:0] minor_c;
  logic [I-1:0]         minc_c;
  logic [PF:0]          omf_c;

  always_comb begin
    case (cmd.sel)
      SEL_FIRST: begin pos_c = p1_r; w_c = w1_r; col_c = col1_r; end
      SEL_LAST:  begin pos_c = p2_r; w_c = w2_r; col_c = col2_r; end
      default:   begin pos_c = t_r; w_c = DW'(1 << F); col_c = x_r[I-1:0]; end
    endcase
    f_c     = pos_c[PF-1:0];
    omf_c   = ((PF+1)'(1) << PF) - {1'b0, f_c};
    minor_c = pos_c[PW-1:PF];
    if (minor_c[MW-1])                     minc_c = '0;
    else if (minor_c > MW'(TILE_MAX))      minc_c = I'(TILE_MAX);
    else                                   minc_c = minor_c[I-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_a) begin
      va_r    <= VW'(omf_c) * VW'(w_c);
      vb_r    <= VW'({1'b0, f_c}) * VW'(w_c);
      colA_r  <= col_c;
      minA_r  <= minc_c;
      lastA_r <= (cmd.sel == SEL_LAST);
    end
  end

  // Second emission stage: scale to coverage with round half up and saturate.
  logic [RW-1:0]         ra, rb;
  logic [RW-CBW-1:0]     qa, qb;
  logic [COVER_BITS-1:0] sa, sb;
  logic [CVW-1:0]        ca, cb;
  logic [I-1:0]          fx, fy;
  logic [I:0]            sx, sy;

  always_comb begin
    ra = RW'(va_r) * RW'(CMAX) + RW'(1 << (CBW - 1));
    rb = RW'(vb_r) * RW'(CMAX) + RW'(1 << (CBW - 1));
    qa = ra[RW-1:CBW];
    qb = rb[RW-1:CBW];
    sa = (qa > (RW-CBW)'(CMAX)) ? COVER_BITS'(CMAX) : qa[COVER_BITS-1:0];
    sb = (qb > (RW-CBW)'(CMAX)) ? COVER_BITS'(CMAX) : qb[COVER_BITS-1:0];
    ca = CVW'(sa);
    cb = CVW'(sb);
    if (steep_r) begin
      fx = minA_r; fy = colA_r;
      sx = {1'b0, minA_r} + 1'b1; sy = {1'b0, colA_r};
    end else begin
      fx = colA_r; fy = minA_r;
      sx = {1'b0, colA_r}; sy = {1'b0, minA_r} + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.write_out) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_out) begin
      od_r <= {6'd0, cb[COV_W-1:0], PX2_W'(sy), PX2_W'(sx), ca[COV_W-1:0],
               PX_W'(fy), PX_W'(fx)};
      ol_r <= lastA_r;
    end
  end

  assign out_tvalid    = ov_r;
  assign out_tdata     = od_r;
  assign out_tlast     = ol_r;
  assign sts.out_free  = !ov_r || out_tready;
  assign sts.div_done  = (cnt_r == '0);
  assign sts.mid_avail = x_r < {1'b0, col2_r};

endmodule

@@ design/antialiased_line_rasterizer.sv @@
// Top level of the antialiased line rasterizer: controller plus datapath.
//
// Each input word carries one line segment with unsigned fixed-point
// endpoints inside a square tile. The block decides whether the line is steep,
// orders the endpoints along the major axis, divides for the gradient and then
// sends one output word per major-axis column: two pixels adjacent along the
// minor axis with their coverages, the endpoint columns weighted by their
// partial major-axis coverage, and tlast set on the final word of the line.
// Setup runs ordering, the restoring gradient divider (COORD_INT_BITS +
// COORD_FRAC_BITS + 16 dividend bits, 26 at the default widths), the gradient
// and the start positions; each output word then passes the two-stage coverage
// multiply and, except after the last word, the column check. Stalls on the
// output side stretch the emission phase. A new line is accepted once the last
// word of the previous one has been loaded into the output register, even
// while that word still waits to be taken.
module antialiased_line_rasterizer #(
  parameter int COORD_INT_BITS  = 6,
  parameter int COORD_FRAC_BITS = 4,
  parameter int COVER_BITS      = 8,
  parameter int IN_TW = ((4 * (COORD_INT_BITS + COORD_FRAC_BITS) + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // Fields from bit 0 up: start_x, start_y, end_x, end_y, each
  // COORD_INT_BITS + COORD_FRAC_BITS wide, zero padding to whole bytes.
  input  logic [IN_TW-1:0]           in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // Fields from bit 0 up: first_px_x (6), first_px_y (6), first_cover (8),
  // second_px_x (7), second_px_y (7), second_cover (8), zero padding.
  output logic [alr_pkg::OUT_TW-1:0] out_tdata,
  // last_column: set on the final word of a line.
  output logic                       out_tlast
);
  import alr_pkg::*;

  alr_cmd_t cmd;
  alr_sts_t sts;

  // The controller only sequences; all arithmetic lives in the datapath.
  alr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  alr_dp #(
    .COORD_INT_BITS  (COORD_INT_BITS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .COVER_BITS      (COVER_BITS),
    .IN_TW           (IN_TW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Once a line is taken, the block is busy with it for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted twice in a row");

  // A fresh output word is only loaded while a line is being emitted.
  a_word_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("output word appeared while idle");

  // Reset leaves no output word pending.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

@@ tb/testbench.sv @@
// Testbench for the antialiased line rasterizer: random and directed lines checked against a predictor.
`timescale 1ns / 100ps

module testbench;
  import alr_pkg::*;

  localparam int CW = 10;
  localparam int FB = 4;
  localparam int PF = 16 + FB;

  typedef struct packed {
    logic [7:0] cov2;
    logic [6:0] py2;
    logic [6:0] px2;
    logic [7:0] cov1;
    logic [5:0] py1;
    logic [5:0] px1;
  } px_pair_t;

  typedef struct {
    px_pair_t pair;
    logic     last;
  } span_word_t;

  // Keeps the expected column words of every accepted line, oldest first.
  class span_scoreboard;
    span_word_t pending[$];
    int         mismatches;

    function longint floor_pos(longint v);
      longint r;
      r = v >>> PF;
      return r;
    endfunction

    function longint to_cover(longint v, int bits);
      longint r;
      r = (v * 255 + (longint'(1) <<< (bits - 1))) >>> bits;
      return (r > 255) ? 255 : r;
    endfunction

    function void push_column(longint col, longint p, longint w, int wbits, bit steep,
                              bit last);
      span_word_t e;
      longint mnr, f;
      int bits;
      mnr = floor_pos(p);
      f = p - (mnr <<< PF);
      bits = PF + wbits;
      if (mnr < 0) mnr = 0;
      if (mnr > 63) mnr = 63;
      if (col < 0) col = 0;
      if (col > 63) col = 63;
      if (steep) begin
        e.pair.px1 = 6'(mnr); e.pair.py1 = 6'(col);
        e.pair.px2 = 7'(mnr + 1); e.pair.py2 = 7'(col);
      end else begin
        e.pair.px1 = 6'(col); e.pair.py1 = 6'(mnr);
        e.pair.px2 = 7'(col); e.pair.py2 = 7'(mnr + 1);
      end
      e.pair.cov1 = 8'(to_cover(((longint'(1) <<< PF) - f) * w, bits));
      e.pair.cov2 = 8'(to_cover(f * w, bits));
      e.last = last;
      pending.push_back(e);
    endfunction

    // Works out every column word of one segment.
    function void note_line(logic [39:0] d);
      longint ax, ay, bx, by, t, dx, dy, g, xe1, xe2, p1, p2, c1, c2, stp, pos;
      bit steep;
      ax = longint'(d[9:0]); ay = longint'(d[19:10]);
      bx = longint'(d[29:20]); by = longint'(d[39:30]);
      steep = ((by > ay) ? by - ay : ay - by) > ((bx > ax) ? bx - ax : ax - bx);
      if (steep) begin
        t = ax; ax = ay; ay = t; t = bx; bx = by; by = t;
      end
      if (ax > bx) begin
        t = ax; ax = bx; bx = t; t = ay; ay = by; by = t;
      end
      dx = bx - ax;
      dy = by - ay;
      if (dx == 0) g = 65536;
      else begin
        g = ((dy < 0 ? -dy : dy) <<< 16) / dx;
        if (dy < 0) g = -g;
      end
      xe1 = (ax + 8) >>> FB;
      p1 = (ay <<< 16) + g * (xe1 * 16 - ax);
      xe2 = (bx + 8) >>> FB;
      p2 = (by <<< 16) + g * (xe2 * 16 - bx);
      c1 = xe1 > 63 ? 63 : xe1;
      c2 = xe2 > 63 ? 63 : xe2;
      push_column(c1, p1, 16 - ((ax + 8) & 15), FB, steep, 0);
      stp = g * 16;
      pos = p1 + stp;
      for (longint x = c1 + 1; x < c2; x++) begin
        push_column(x, pos, 1, 0, steep, 0);
        pos += stp;
      end
      push_column(c2, p2, (bx + 8) & 15, FB, steep, 1);
    endfunction

    function void check_word(logic [47:0] d, logic last);
      span_word_t e;
      px_pair_t got;
      got = d[41:0];
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected word %h last %b", d, last);
        return;
      end
      e = pending.pop_front();
      if (got !== e.pair || last !== e.last || d[47:42] !== 6'd0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Word mismatch: expected %h last %b, got %h last %b",
                   e.pair, e.last, d, last);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tready;
  logic [39:0] in_tdata = '0;
  logic out_tvalid, out_tready = 0, out_tlast;
  logic [OUT_TW-1:0] out_tdata;
  span_scoreboard sb = new();
  bit calm = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  antialiased_line_rasterizer dut (.*);

  // Result side: random stall bursts until the calm final stretch.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(3) == 0) begin
        out_tready <= 0;
        n = $urandom_range(7, 1);
        repeat (n) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata, out_tlast);

  // Hands one segment to the block and waits for it to be taken; valid stays
  // high afterwards so that the next segment can follow without a gap.
  task automatic send_line(logic [9:0] sx, sy, ex, ey);
    int n;
    if (!calm && $urandom_range(3) == 0) begin
      in_tvalid <= 0;
      n = $urandom_range(7, 1);
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {ey, ex, sy, sx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_line({ey, ex, sy, sx});
  endtask

  function automatic logic [9:0] rnd_coord();
    case ($urandom_range(5))
      0: return 10'($urandom_range(15));
      1: return 10'(1023 - $urandom_range(31));
      default: return 10'($urandom);
    endcase
  endfunction

  initial begin
    logic [9:0] sx, sy;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: extremes, degenerate point, single column, steep and shallow,
    // both directions, off-tile patterns.
    send_line(10'd0, 10'd0, 10'd0, 10'd0);
    send_line(10'd1023, 10'd1023, 10'd1023, 10'd1023);
    send_line(10'd0, 10'd0, 10'd1007, 10'd1007);
    send_line(10'd1007, 10'd0, 10'd0, 10'd1007);
    send_line(10'd0, 10'd500, 10'd1023, 10'd500);
    send_line(10'd500, 10'd0, 10'd500, 10'd1023);
    send_line(10'd1023, 10'd0, 10'd0, 10'd1023);
    send_line(10'd100, 10'd100, 10'd106, 10'd103);
    send_line(10'd104, 10'd200, 10'd104, 10'd207);
    send_line(10'd8, 10'd8, 10'd24, 10'd8);
    send_line(10'd7, 10'd7, 10'd23, 10'd40);
    send_line(10'd300, 10'd900, 10'd40, 10'd10);
    send_line(10'd1000, 10'd3, 10'd20, 10'd1020);
    send_line(10'd0, 10'd1023, 10'd1023, 10'd0);
    send_line(10'd600, 10'd600, 10'd601, 10'd601);
    send_line(10'd1023, 10'd512, 10'd0, 10'd513);
    send_line(10'h2aa, 10'h155, 10'h155, 10'h2aa);
    in_tvalid <= 0;
    // Pause until the block has drained.
    while (sb.pending.size() != 0) @(posedge clk);
    for (int i = 0; i < 93; i++) begin
      if (i == 75) calm = 1;
      sx = rnd_coord();
      sy = rnd_coord();
      if ($urandom_range(3) == 0)
        send_line(sx, sy, 10'(sx + $urandom_range(40)), 10'(sy + $urandom_range(40)));
      else
        send_line(sx, sy, rnd_coord(), rnd_coord());
    end
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
